@@ hw/rtl/cgm_pkg.sv @@
package cgm_pkg;

   localparam int ROW_BITS     = 11;
   localparam int COL_BITS     = 11;
   localparam int RESP_BITS    = 17;
   localparam int MAG_BITS     = 16;
   localparam int DIM_BITS     = 12;
   localparam int INROW_BITS   = 12;
   localparam int CSR_IDX_BITS = 3;
   localparam int TAPS         = 9;
   localparam int QUEUE_DEPTH  = 2;
   localparam int SQ_BITS      = 34;
   localparam int ROOT_STEPS   = 17;

   localparam logic [CSR_IDX_BITS-1:0] CSR_KERNEL_X = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_KERNEL_Y = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WIDTH    = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HEIGHT   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MODE     = 3'd4;

   localparam logic KIND_FLUSH = 1'b1;

   localparam logic [DIM_BITS-1:0]   MAX_HEIGHT  = 12'd2048;
   localparam logic [DIM_BITS-1:0]   RST_WIDTH   = 12'd640;
   localparam logic [DIM_BITS-1:0]   RST_HEIGHT  = 12'd480;
   localparam logic [INROW_BITS-1:0] INROW_MAX   = 12'd4095;
   localparam logic [ROW_BITS-1:0]   OUTROW_MAX  = 11'd2047;

   typedef enum logic [0:0] {
      F_IDLE,
      F_UPD
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_MAC,
      B_SQX,
      B_SQY,
      B_ROOT,
      B_OUT
   } back_state_type;

   typedef struct packed {
      logic [ROW_BITS-1:0] row;
      logic [COL_BITS-1:0] col;
      logic                last;
   } pos_type;

endpackage

@@ hw/rtl/conv3x3_gradient_magnitude_unit.sv @@
// channel | direction | fields                                          | handshake
// req     | in        | kind, pixel                                     | req_valid / req_stall
// rsp     | out       | response_x/y, magnitude, result_value, row, col, last | rsp_valid / rsp_stall
// csr     | in        | index, wdata                                    | csr_we
//
// Front reads the line buffers, takes an item, then stalls req while it updates the window.
// Back steps through the MAC over all taps, squaring, the square-root iteration and output,
// handling one item at a time; the square-root iteration sets the rate.
// Reset is synchronous and clears counters, window and queue; line buffers are not cleared.
// A 2-entry queue lets the front keep accepting while rsp is stalled, until the queue is full.
module conv3x3_gradient_magnitude_unit
   import cgm_pkg::*;
#(
   parameter int MAX_WIDTH  = 2048,
   parameter int PIXEL_BITS = 8,
   parameter int COEFF_BITS = 5
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_kind,
   input  logic [PIXEL_BITS-1:0]        req_pixel,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [RESP_BITS-1:0]  rsp_response_x,
   output logic signed [RESP_BITS-1:0]  rsp_response_y,
   output logic [MAG_BITS-1:0]          rsp_magnitude,
   output logic signed [RESP_BITS-1:0]  rsp_result_value,
   output logic [ROW_BITS-1:0]          rsp_out_row,
   output logic [COL_BITS-1:0]          rsp_out_col,
   output logic                         rsp_last,
   input  logic                         csr_we,
   input  logic [CSR_IDX_BITS-1:0]      csr_index,
   input  logic [TAPS*COEFF_BITS-1:0]   csr_wdata
);

   localparam int WRAW = $clog2(MAX_WIDTH + 1);
   localparam int WB   = (WRAW > DIM_BITS) ? WRAW : DIM_BITS;
   localparam int KB   = TAPS * COEFF_BITS;
   localparam int QW   = TAPS * PIXEL_BITS + $bits(pos_type);

   logic [KB-1:0]       kx_ff, ky_ff;
   logic [DIM_BITS-1:0] fw_ff, fh_ff, h_eff;
   logic                mode_ff;
   logic [WB-1:0]       w_eff;
   logic                push, pop, q_full, q_empty;
   logic [TAPS*PIXEL_BITS-1:0] push_pix, q_pix;
   pos_type             push_pos, q_pos;
   logic [QW-1:0]       q_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         kx_ff   <= '0;
         ky_ff   <= '0;
         fw_ff   <= RST_WIDTH;
         fh_ff   <= RST_HEIGHT;
         mode_ff <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_KERNEL_X: kx_ff   <= csr_wdata;
            CSR_KERNEL_Y: ky_ff   <= csr_wdata;
            CSR_WIDTH:    fw_ff   <= csr_wdata[DIM_BITS-1:0];
            CSR_HEIGHT:   fh_ff   <= csr_wdata[DIM_BITS-1:0];
            CSR_MODE:     mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (fw_ff == '0)                       w_eff = WB'(1);
      else if (WB'(fw_ff) > WB'(MAX_WIDTH))  w_eff = WB'(MAX_WIDTH);
      else                                   w_eff = WB'(fw_ff);
      if (fh_ff == '0)              h_eff = DIM_BITS'(1);
      else if (fh_ff > MAX_HEIGHT)  h_eff = MAX_HEIGHT;
      else                          h_eff = fh_ff;
   end

   cgm_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .PIXEL_BITS(PIXEL_BITS),
      .WB        (WB)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind (req_kind),
      .req_pixel(req_pixel),
      .w_eff    (w_eff),
      .h_eff    (h_eff),
      .q_full   (q_full),
      .push     (push),
      .push_pix (push_pix),
      .push_pos (push_pos)
   );

   cgm_queue #(
      .WIDTH(QW)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data({push_pix, push_pos}),
      .pop      (pop),
      .pop_data (q_out),
      .full     (q_full),
      .empty    (q_empty)
   );

   assign q_pix = q_out[QW-1 -: TAPS*PIXEL_BITS];
   assign q_pos = q_out[$bits(pos_type)-1:0];

   cgm_back #(
      .PIXEL_BITS(PIXEL_BITS),
      .COEFF_BITS(COEFF_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .pop             (pop),
      .q_pix           (q_pix),
      .q_pos           (q_pos),
      .kernel_x        (kx_ff),
      .kernel_y        (ky_ff),
      .mode            (mode_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_response_x  (rsp_response_x),
      .rsp_response_y  (rsp_response_y),
      .rsp_magnitude   (rsp_magnitude),
      .rsp_result_value(rsp_result_value),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_last        (rsp_last)
   );

endmodule

@@ hw/rtl/cgm_front.sv @@
module cgm_front
   import cgm_pkg::*;
#(
   parameter int MAX_WIDTH  = 2048,
   parameter int PIXEL_BITS = 8,
   parameter int WB         = 12
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_kind,
   input  logic [PIXEL_BITS-1:0]     req_pixel,
   input  logic [WB-1:0]             w_eff,
   input  logic [DIM_BITS-1:0]       h_eff,
   input  logic                      q_full,
   output logic                      push,
   output logic [TAPS*PIXEL_BITS-1:0] push_pix,
   output pos_type                   push_pos
);

   localparam int XB = $clog2(MAX_WIDTH);

   front_state_type        st_ff, st_in;
   logic [XB-1:0]          x_ff, x_in;
   logic [INROW_BITS-1:0]  y_ff, y_in;
   logic [ROW_BITS-1:0]    orow_ff, orow_in;
   logic [COL_BITS-1:0]    ocol_ff, ocol_in;
   logic [PIXEL_BITS-1:0]  cur_ff, cur_in;
   logic [PIXEL_BITS-1:0]  win_ff [TAPS];
   logic [PIXEL_BITS-1:0]  win_in [TAPS];
   logic [PIXEL_BITS-1:0]  src    [TAPS];
   logic [PIXEL_BITS-1:0]  rd_u_ff, rd_m_ff;
   logic [PIXEL_BITS-1:0]  mem_u [MAX_WIDTH];
   logic [PIXEL_BITS-1:0]  mem_m [MAX_WIDTH];
   logic [1:0]             rsel [3];
   logic [1:0]             csel [3];
   logic [1:0]             cc;
   logic                   accept, drain, primed, row_end, col_end, x_end, last;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (st_ff != F_IDLE) || q_full;
   assign drain     = h_eff <= y_ff;

   always_comb begin
      st_in   = st_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      orow_in = orow_ff;
      ocol_in = ocol_ff;
      cur_in  = cur_ff;
      push    = 1'b0;
      for (int r = 0; r < 3; r++) begin
         win_in[r*3]   = win_ff[r*3+1];
         win_in[r*3+1] = win_ff[r*3+2];
      end
      win_in[2] = rd_u_ff;
      win_in[5] = rd_m_ff;
      win_in[8] = cur_ff;

      primed  = (y_ff >= INROW_BITS'(2)) || (y_ff == INROW_BITS'(1) && x_ff != '0);
      cc      = (x_ff == '0) ? 2'd2 : 2'd1;
      for (int i = 0; i < TAPS; i++) begin
         src[i] = (x_ff == '0) ? win_ff[i] : win_in[i];
      end
      row_end = ({1'b0, orow_ff} + DIM_BITS'(1)) >= h_eff;
      col_end = (WB'(ocol_ff) + WB'(1)) >= w_eff;
      x_end   = (WB'(x_ff) + WB'(1)) >= w_eff;
      last    = row_end && col_end;
      rsel[0] = (orow_ff == '0) ? 2'd1 : 2'd0;
      rsel[1] = 2'd1;
      rsel[2] = row_end ? 2'd1 : 2'd2;
      csel[0] = (ocol_ff == '0) ? cc : cc - 2'd1;
      csel[1] = cc;
      csel[2] = (col_end || cc == 2'd2) ? cc : cc + 2'd1;
      for (int i = 0; i < TAPS; i++) begin
         push_pix[i*PIXEL_BITS +: PIXEL_BITS] = src[rsel[i/3]*3 + csel[i%3]];
      end
      push_pos.row  = orow_ff;
      push_pos.col  = ocol_ff;
      push_pos.last = last;

      unique case (st_ff)
         F_IDLE: begin
            if (accept && (drain || req_kind != KIND_FLUSH)) begin
               cur_in = drain ? '0 : req_pixel;
               st_in  = F_UPD;
            end
         end
         F_UPD: begin
            st_in = F_IDLE;
            if (primed) begin
               push = 1'b1;
               if (col_end) begin
                  ocol_in = '0;
                  if (orow_ff < OUTROW_MAX) orow_in = orow_ff + ROW_BITS'(1);
               end else begin
                  ocol_in = ocol_ff + COL_BITS'(1);
               end
            end
            if (x_end) begin
               x_in = '0;
               if (y_ff < INROW_MAX) y_in = y_ff + INROW_BITS'(1);
            end else begin
               x_in = x_ff + XB'(1);
            end
            if (primed && last) begin
               x_in    = '0;
               y_in    = '0;
               orow_in = '0;
               ocol_in = '0;
            end
         end
         default: st_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= F_IDLE;
         x_ff    <= '0;
         y_ff    <= '0;
         orow_ff <= '0;
         ocol_ff <= '0;
         for (int i = 0; i < TAPS; i++) win_ff[i] <= '0;
      end else begin
         st_ff   <= st_in;
         x_ff    <= x_in;
         y_ff    <= y_in;
         orow_ff <= orow_in;
         ocol_ff <= ocol_in;
         if (st_ff == F_UPD) begin
            for (int i = 0; i < TAPS; i++) win_ff[i] <= win_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      rd_u_ff <= mem_u[x_ff];
      rd_m_ff <= mem_m[x_ff];
      if (st_ff == F_UPD) begin
         mem_u[x_ff] <= rd_m_ff;
         mem_m[x_ff] <= cur_ff;
      end
   end

endmodule

@@ hw/rtl/cgm_queue.sv @@
module cgm_queue
   import cgm_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   localparam int PB = $clog2(QUEUE_DEPTH);
   localparam int CB = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [PB-1:0]    wp_ff, wp_in, rp_ff, rp_in;
   logic [CB-1:0]    cnt_ff, cnt_in;

   assign full     = cnt_ff == CB'(QUEUE_DEPTH);
   assign empty    = cnt_ff == '0;
   assign pop_data = slot_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wp_in = (wp_ff == PB'(QUEUE_DEPTH - 1)) ? '0 : wp_ff + PB'(1);
      end
      if (pop) begin
         rp_in = (rp_ff == PB'(QUEUE_DEPTH - 1)) ? '0 : rp_ff + PB'(1);
      end
      if (push && !pop) cnt_in = cnt_ff + CB'(1);
      if (pop && !push) cnt_in = cnt_ff - CB'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wp_ff] <= push_data;
   end

endmodule

@@ hw/rtl/cgm_back.sv @@
module cgm_back
   import cgm_pkg::*;
#(
   parameter int PIXEL_BITS = 8,
   parameter int COEFF_BITS = 5
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_empty,
   output logic                        pop,
   input  logic [TAPS*PIXEL_BITS-1:0]  q_pix,
   input  pos_type                     q_pos,
   input  logic [TAPS*COEFF_BITS-1:0]  kernel_x,
   input  logic [TAPS*COEFF_BITS-1:0]  kernel_y,
   input  logic                        mode,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [RESP_BITS-1:0] rsp_response_x,
   output logic signed [RESP_BITS-1:0] rsp_response_y,
   output logic [MAG_BITS-1:0]         rsp_magnitude,
   output logic signed [RESP_BITS-1:0] rsp_result_value,
   output logic [ROW_BITS-1:0]         rsp_out_row,
   output logic [COL_BITS-1:0]         rsp_out_col,
   output logic                        rsp_last
);

   localparam int ACC_RAW = PIXEL_BITS + COEFF_BITS + 5;
   localparam int ACC_W   = (ACC_RAW > 18) ? ACC_RAW : 18;
   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(65535);
   localparam logic signed [ACC_W-1:0] SAT_LO = -(ACC_W'(65536));

   back_state_type               st_ff, st_in;
   logic [3:0]                   tap_ff, tap_in;
   logic [4:0]                   k_ff, k_in;
   logic signed [ACC_W-1:0]      accx_ff, accx_in, accy_ff, accy_in;
   logic [TAPS*PIXEL_BITS-1:0]   pix_ff, pix_in;
   pos_type                      pos_ff, pos_in;
   logic signed [RESP_BITS-1:0]  gx_ff, gx_in, gy_ff, gy_in;
   logic [SQ_BITS-1:0]           sq_ff, sq_in, rem_ff, rem_in, root_ff, root_in;
   logic signed [SQ_BITS-1:0]    sqr;
   logic [SQ_BITS-1:0]           bitv, trial;
   logic signed [COEFF_BITS-1:0] cx, cy;
   logic signed [PIXEL_BITS:0]   pv;
   logic                         load;
   logic                         out_v_ff, out_v_in;
   logic signed [RESP_BITS-1:0]  o_x_ff, o_x_in, o_y_ff, o_y_in, o_r_ff, o_r_in;
   logic [MAG_BITS-1:0]          o_m_ff, o_m_in, mag;
   pos_type                      o_p_ff, o_p_in;

   function automatic logic signed [RESP_BITS-1:0] sat(input logic signed [ACC_W-1:0] a);
      logic signed [RESP_BITS-1:0] s;
      if (a > SAT_HI)      s = 17'sh0FFFF;
      else if (a < SAT_LO) s = 17'sh10000;
      else                 s = a[RESP_BITS-1:0];
      return s;
   endfunction

   assign rsp_valid        = out_v_ff;
   assign rsp_response_x   = o_x_ff;
   assign rsp_response_y   = o_y_ff;
   assign rsp_magnitude    = o_m_ff;
   assign rsp_result_value = o_r_ff;
   assign rsp_out_row      = o_p_ff.row;
   assign rsp_out_col      = o_p_ff.col;
   assign rsp_last         = o_p_ff.last;

   always_comb begin
      st_in    = st_ff;
      tap_in   = tap_ff;
      k_in     = k_ff;
      accx_in  = accx_ff;
      accy_in  = accy_ff;
      pix_in   = pix_ff;
      pos_in   = pos_ff;
      gx_in    = gx_ff;
      gy_in    = gy_ff;
      sq_in    = sq_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      pop      = 1'b0;
      load     = 1'b0;
      cx       = kernel_x[tap_ff*COEFF_BITS +: COEFF_BITS];
      cy       = kernel_y[tap_ff*COEFF_BITS +: COEFF_BITS];
      pv       = $signed({1'b0, pix_ff[tap_ff*PIXEL_BITS +: PIXEL_BITS]});
      bitv     = SQ_BITS'(1) << {k_ff, 1'b0};
      trial    = root_ff + bitv;
      sqr      = (st_ff == B_SQX) ? gx_ff * gx_ff : gy_ff * gy_ff;
      mag      = (root_ff > SQ_BITS'(65535)) ? 16'hFFFF : root_ff[MAG_BITS-1:0];

      unique case (st_ff)
         B_IDLE: begin
            if (!q_empty) begin
               pop     = 1'b1;
               pix_in  = q_pix;
               pos_in  = q_pos;
               accx_in = '0;
               accy_in = '0;
               tap_in  = '0;
               st_in   = B_MAC;
            end
         end
         B_MAC: begin
            accx_in = accx_ff + ACC_W'(cx * pv);
            accy_in = accy_ff + ACC_W'(cy * pv);
            tap_in  = tap_ff + 4'd1;
            if (tap_ff == 4'(TAPS - 1)) begin
               gx_in = sat(accx_in);
               gy_in = sat(accy_in);
               st_in = B_SQX;
            end
         end
         B_SQX: begin
            sq_in = sqr;
            st_in = B_SQY;
         end
         B_SQY: begin
            rem_in  = sq_ff + sqr;
            root_in = '0;
            k_in    = 5'(ROOT_STEPS - 1);
            st_in   = B_ROOT;
         end
         B_ROOT: begin
            if (rem_ff >= trial) begin
               rem_in  = rem_ff - trial;
               root_in = (root_ff >> 1) + bitv;
            end else begin
               root_in = root_ff >> 1;
            end
            k_in = k_ff - 5'd1;
            if (k_ff == '0) st_in = B_OUT;
         end
         B_OUT: begin
            if (!out_v_ff || !rsp_stall) begin
               load  = 1'b1;
               st_in = B_IDLE;
            end
         end
         default: st_in = B_IDLE;
      endcase

      out_v_in = load ? 1'b1 : (out_v_ff && rsp_stall);
      o_x_in   = load ? gx_ff : o_x_ff;
      o_y_in   = load ? gy_ff : o_y_ff;
      o_m_in   = load ? mag : o_m_ff;
      o_r_in   = load ? (mode ? $signed({1'b0, mag}) : gx_ff) : o_r_ff;
      o_p_in   = load ? pos_ff : o_p_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= B_IDLE;
         out_v_ff <= 1'b0;
      end else begin
         st_ff    <= st_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      tap_ff  <= tap_in;
      k_ff    <= k_in;
      accx_ff <= accx_in;
      accy_ff <= accy_in;
      pix_ff  <= pix_in;
      pos_ff  <= pos_in;
      gx_ff   <= gx_in;
      gy_ff   <= gy_in;
      sq_ff   <= sq_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      o_x_ff  <= o_x_in;
      o_y_ff  <= o_y_in;
      o_m_ff  <= o_m_in;
      o_r_ff  <= o_r_in;
      o_p_ff  <= o_p_in;
   end

endmodule

@@ hw/rtl/cgm_checker.sv @@
module cgm_checker
   import cgm_pkg::*;
(
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic signed [RESP_BITS-1:0] rsp_response_x,
   input logic [MAG_BITS-1:0]         rsp_magnitude,
   input logic signed [RESP_BITS-1:0] rsp_result_value
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   a_payload_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_magnitude) && $stable(rsp_result_value))
      else $error("rsp payload changed while stalled");

   a_mag_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_response_x[RESP_BITS-1] |->
      rsp_magnitude >= rsp_response_x[MAG_BITS-1:0])
      else $error("magnitude below response_x");

endmodule

bind conv3x3_gradient_magnitude_unit cgm_checker u_cgm_checker (.*);
